// ----- design/assert_macros.svh -----
// Assertion macros for the design files; only the top-level core includes them.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- design/eul2rot_pkg.sv -----
// Shared constants, lane type and arctangent table for the Euler-to-matrix core.
// No dependencies.
package eul2rot_pkg;

    localparam int ANGLE_BITS_DEF      = 16;
    localparam int COEFF_FRAC_BITS_DEF = 14;
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int MAX_STAGES          = 24;

    localparam int FIELD_BITS    = 16;
    localparam int NUM_ANGLES    = 3;
    localparam int NUM_ENTRIES   = 9;
    localparam int IN_DATA_BITS  = FIELD_BITS * NUM_ANGLES;
    localparam int OUT_DATA_BITS = FIELD_BITS * NUM_ENTRIES;

    localparam int TURN_BITS = 32;
    localparam int XY_BITS   = 32;
    localparam int Z_BITS    = 33;
    localparam int INT_FRAC  = 30;

    localparam logic signed [XY_BITS-1:0] GAIN_INIT    = 32'sd652032874;
    localparam logic signed [Z_BITS-1:0]  QUARTER_TURN = 33'sh040000000;
    localparam logic signed [Z_BITS-1:0]  HALF_TURN    = 33'sh080000000;

    localparam int LANE_YAW   = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_ROLL  = 2;

    typedef struct packed {
        logic signed [XY_BITS-1:0] x;
        logic signed [XY_BITS-1:0] y;
        logic signed [Z_BITS-1:0]  z;
        logic                      flip;
    } lane_t;

    // atan(2^-i) in turns, scaled by 2^32
    function automatic logic [TURN_BITS-1:0] atan_turn(input int idx);
        logic [TURN_BITS-1:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/eul2rot_cordic_cell.sv -----
// One CORDIC micro-rotation for the yaw, pitch and roll lanes, with its own
// handshake register. Depends on eul2rot_pkg.
module eul2rot_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  eul2rot_pkg::lane_t [eul2rot_pkg::NUM_ANGLES-1:0] in_lanes,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output eul2rot_pkg::lane_t [eul2rot_pkg::NUM_ANGLES-1:0] out_lanes
);

    localparam logic signed [eul2rot_pkg::Z_BITS-1:0] ATAN_Z =
        signed'({1'b0, eul2rot_pkg::atan_turn(STAGE)});

    eul2rot_pkg::lane_t [eul2rot_pkg::NUM_ANGLES-1:0] lanes_reg, lanes_next;
    logic valid_reg;

    always_comb begin
        for (int k = 0; k < eul2rot_pkg::NUM_ANGLES; k++) begin
            lanes_next[k] = in_lanes[k];
            if (!in_lanes[k].z[eul2rot_pkg::Z_BITS-1]) begin
                lanes_next[k].x = in_lanes[k].x - (in_lanes[k].y >>> STAGE);
                lanes_next[k].y = in_lanes[k].y + (in_lanes[k].x >>> STAGE);
                lanes_next[k].z = in_lanes[k].z - ATAN_Z;
            end else begin
                lanes_next[k].x = in_lanes[k].x + (in_lanes[k].y >>> STAGE);
                lanes_next[k].y = in_lanes[k].y - (in_lanes[k].x >>> STAGE);
                lanes_next[k].z = in_lanes[k].z + ATAN_Z;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            lanes_reg <= lanes_next;
        end
    end

endmodule

// ----- design/eul2rot_matrix.sv -----
// Three-stage product and sum pipeline forming the nine matrix entries from
// the sines and cosines. Depends on eul2rot_pkg.
module eul2rot_matrix #(
    parameter int COEFF_FRAC_BITS = eul2rot_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [COEFF_FRAC_BITS+1:0]       cy,
    input  logic signed [COEFF_FRAC_BITS+1:0]       sy,
    input  logic signed [COEFF_FRAC_BITS+1:0]       cp,
    input  logic signed [COEFF_FRAC_BITS+1:0]       sp,
    input  logic signed [COEFF_FRAC_BITS+1:0]       cr,
    input  logic signed [COEFF_FRAC_BITS+1:0]       sr,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [eul2rot_pkg::OUT_DATA_BITS-1:0]   out_data
);

    localparam int CW = COEFF_FRAC_BITS + 2;
    localparam int PW = 2 * CW;
    localparam int FB = eul2rot_pkg::FIELD_BITS;
    localparam logic signed [PW-1:0] PROD_HALF = PW'(1) << (COEFF_FRAC_BITS - 1);
    localparam logic signed [CW:0]   SUM_ONE   = (CW + 1)'(1) << COEFF_FRAC_BITS;

    function automatic logic signed [CW-1:0] rprod(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        logic signed [PW-1:0] p;
        p = a * b;
        p = p + PROD_HALF;
        p = p >>> COEFF_FRAC_BITS;
        return CW'(p);
    endfunction

    function automatic logic signed [CW:0] sat_one(input logic signed [CW:0] v);
        logic signed [CW:0] r;
        r = v;
        if (v > SUM_ONE) begin
            r = SUM_ONE;
        end else if (v < -SUM_ONE) begin
            r = -SUM_ONE;
        end
        return r;
    endfunction

    // stage A: first-level products
    logic signed [CW-1:0] cysp_reg, sysp_reg, m00_reg, m10_reg, m21_reg, m22_reg;
    logic signed [CW-1:0] crsy_reg, sysr_reg, crcy_reg, cysr_reg;
    logic signed [CW-1:0] sr_a_reg, cr_a_reg, sp_a_reg;
    logic a_valid_reg;
    logic a_ready;

    // stage B: triple products
    logic signed [CW-1:0] p01_reg, p02_reg, p11_reg, p12_reg;
    logic signed [CW-1:0] m00_b_reg, m10_b_reg, m21_b_reg, m22_b_reg;
    logic signed [CW-1:0] crsy_b_reg, sysr_b_reg, crcy_b_reg, cysr_b_reg, sp_b_reg;
    logic b_valid_reg;
    logic b_ready;

    // stage C: sums, saturation, output word
    logic [eul2rot_pkg::OUT_DATA_BITS-1:0] data_reg, data_next;
    logic c_valid_reg;
    logic c_ready;
    logic signed [CW:0] ent [eul2rot_pkg::NUM_ENTRIES];

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            cysp_reg <= rprod(cy, sp);
            sysp_reg <= rprod(sy, sp);
            m00_reg  <= rprod(cp, cy);
            m10_reg  <= rprod(cp, sy);
            m21_reg  <= rprod(sr, cp);
            m22_reg  <= rprod(cr, cp);
            crsy_reg <= rprod(cr, sy);
            sysr_reg <= rprod(sy, sr);
            crcy_reg <= rprod(cr, cy);
            cysr_reg <= rprod(cy, sr);
            sr_a_reg <= sr;
            cr_a_reg <= cr;
            sp_a_reg <= sp;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready) begin
            p01_reg    <= rprod(cysp_reg, sr_a_reg);
            p02_reg    <= rprod(cysp_reg, cr_a_reg);
            p11_reg    <= rprod(sysp_reg, sr_a_reg);
            p12_reg    <= rprod(sysp_reg, cr_a_reg);
            m00_b_reg  <= m00_reg;
            m10_b_reg  <= m10_reg;
            m21_b_reg  <= m21_reg;
            m22_b_reg  <= m22_reg;
            crsy_b_reg <= crsy_reg;
            sysr_b_reg <= sysr_reg;
            crcy_b_reg <= crcy_reg;
            cysr_b_reg <= cysr_reg;
            sp_b_reg   <= sp_a_reg;
        end
    end

    always_comb begin
        ent[0] = (CW + 1)'(m00_b_reg);
        ent[1] = (CW + 1)'(p01_reg) - (CW + 1)'(crsy_b_reg);
        ent[2] = (CW + 1)'(p02_reg) + (CW + 1)'(sysr_b_reg);
        ent[3] = (CW + 1)'(m10_b_reg);
        ent[4] = (CW + 1)'(p11_reg) + (CW + 1)'(crcy_b_reg);
        ent[5] = (CW + 1)'(p12_reg) - (CW + 1)'(cysr_b_reg);
        ent[6] = -((CW + 1)'(sp_b_reg));
        ent[7] = (CW + 1)'(m21_b_reg);
        ent[8] = (CW + 1)'(m22_b_reg);
        data_next = '0;
        for (int k = 0; k < eul2rot_pkg::NUM_ENTRIES; k++) begin
            data_next[FB*k +: FB] = FB'(sat_one(ent[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- design/euler_to_rotation_matrix_core.sv -----
// Top level: Z-Y-X Euler angles to a 3x3 rotation matrix in signed fixed point.
// Depends on eul2rot_pkg, eul2rot_cordic_cell, eul2rot_matrix, assert_macros.svh.
//
// Takes one word of three 16-bit binary angles (65536 = one turn) per cycle
// and returns one word of nine saturated matrix entries per input word, in
// order. The pipeline is an angle register with quarter-turn range
// reduction, one cell per CORDIC micro-rotation, a rounding stage for sine
// and cosine, and three product/sum stages. Throughput is one word per
// clock, set by the fully unrolled cell chain; every stage holds its own
// valid bit, so bubbles collapse and input is refused only when the whole
// pipeline is full and the output is stalled.
`include "assert_macros.svh"

module euler_to_rotation_matrix_core #(
    parameter int ANGLE_BITS      = eul2rot_pkg::ANGLE_BITS_DEF,
    parameter int COEFF_FRAC_BITS = eul2rot_pkg::COEFF_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = eul2rot_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [15:0] yaw_angle, [31:16] pitch_angle, [47:32] roll_angle
    input  logic [eul2rot_pkg::IN_DATA_BITS-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [15:0] m00, [31:16] m01, [47:32] m02, [63:48] m10, [79:64] m11,
    // [95:80] m12, [111:96] m20, [127:112] m21, [143:128] m22
    output logic [eul2rot_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

    localparam int STAGES = (CORDIC_STAGES > eul2rot_pkg::MAX_STAGES) ?
                            eul2rot_pkg::MAX_STAGES : CORDIC_STAGES;
    localparam int NA   = eul2rot_pkg::NUM_ANGLES;
    localparam int FB   = eul2rot_pkg::FIELD_BITS;
    localparam int TB   = eul2rot_pkg::TURN_BITS;
    localparam int ZB   = eul2rot_pkg::Z_BITS;
    localparam int XB   = eul2rot_pkg::XY_BITS;
    localparam int CW   = COEFF_FRAC_BITS + 2;
    localparam int DROP = (ANGLE_BITS < FB) ? (FB - ANGLE_BITS) : 0;
    localparam int TSH  = TB - FB + DROP;
    localparam int RSH  = eul2rot_pkg::INT_FRAC - COEFF_FRAC_BITS;
    localparam int RW   = XB + 2;
    localparam logic signed [RW-1:0] RND_HALF = RW'(1) << (RSH - 1);
    localparam logic signed [RW-1:0] RND_ONE  = RW'(1) << COEFF_FRAC_BITS;
    localparam logic signed [CW-1:0] TRIG_ONE = CW'(1) << COEFF_FRAC_BITS;

    // angle field to CORDIC start vector, range reduced to a quarter turn
    function automatic eul2rot_pkg::lane_t start_lane(input logic [FB-1:0] field);
        logic [TB-1:0]              turn;
        logic signed [ZB-1:0]       z;
        eul2rot_pkg::lane_t         l;
        turn = ({field, {(TB - FB){1'b0}}} >> TSH) << TSH;
        z    = signed'({turn[TB-1], turn});
        l.x  = eul2rot_pkg::GAIN_INIT;
        l.y  = '0;
        l.flip = 1'b0;
        if (z > eul2rot_pkg::QUARTER_TURN) begin
            l.z    = z - eul2rot_pkg::HALF_TURN;
            l.flip = 1'b1;
        end else if (z < -eul2rot_pkg::QUARTER_TURN) begin
            l.z    = z + eul2rot_pkg::HALF_TURN;
            l.flip = 1'b1;
        end else begin
            l.z = z;
        end
        return l;
    endfunction

    function automatic logic signed [CW-1:0] trig_round(input logic signed [XB-1:0] v,
                                                        input logic neg);
        logic signed [RW-1:0] w;
        w = RW'(v);
        if (neg) begin
            w = -w;
        end
        w = (w + RND_HALF) >>> RSH;
        if (w > RND_ONE) begin
            w = RND_ONE;
        end else if (w < -RND_ONE) begin
            w = -RND_ONE;
        end
        return CW'(w);
    endfunction

    eul2rot_pkg::lane_t [NA-1:0] lane0_reg, lane0_next;
    logic valid0_reg;

    eul2rot_pkg::lane_t [NA-1:0] chain_lanes [0:STAGES];
    logic [STAGES:0] chain_valid;
    logic [STAGES:0] chain_ready;

    logic signed [CW-1:0] cos_reg [NA];
    logic signed [CW-1:0] sin_reg [NA];
    logic trig_valid_reg;
    logic trig_ready;
    logic mat_ready;

    // input register
    always_comb begin
        for (int k = 0; k < NA; k++) begin
            lane0_next[k] = start_lane(s_tdata[FB*k +: FB]);
        end
    end

    assign s_tready = !valid0_reg || chain_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= 1'b0;
        end else if (s_tready) begin
            valid0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            lane0_reg <= lane0_next;
        end
    end

    assign chain_lanes[0] = lane0_reg;
    assign chain_valid[0] = valid0_reg;

    // CORDIC cell chain
    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        eul2rot_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_lanes  (chain_lanes[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_lanes (chain_lanes[g+1])
        );
    end

    // sine/cosine rounding
    assign trig_ready          = !trig_valid_reg || mat_ready;
    assign chain_ready[STAGES] = trig_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_valid_reg <= 1'b0;
        end else if (trig_ready) begin
            trig_valid_reg <= chain_valid[STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (trig_ready) begin
            for (int k = 0; k < NA; k++) begin
                cos_reg[k] <= trig_round(chain_lanes[STAGES][k].x,
                                         chain_lanes[STAGES][k].flip);
                sin_reg[k] <= trig_round(chain_lanes[STAGES][k].y,
                                         chain_lanes[STAGES][k].flip);
            end
        end
    end

    eul2rot_matrix #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (trig_valid_reg),
        .in_ready  (mat_ready),
        .cy        (cos_reg[eul2rot_pkg::LANE_YAW]),
        .sy        (sin_reg[eul2rot_pkg::LANE_YAW]),
        .cp        (cos_reg[eul2rot_pkg::LANE_PITCH]),
        .sp        (sin_reg[eul2rot_pkg::LANE_PITCH]),
        .cr        (cos_reg[eul2rot_pkg::LANE_ROLL]),
        .sr        (sin_reg[eul2rot_pkg::LANE_ROLL]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // input is refused only when every stage is full and the output is stalled
    `ASSERT_IMPL(a_full_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready)
    // an accepted word is always held in the angle register next cycle
    `ASSERT_NEXT(a_accept_lands, aclk, aresetn, s_tvalid && s_tready, valid0_reg)
    `ASSERT_IMPL(a_cos_pitch_bound, aclk, aresetn, trig_valid_reg,
                 (cos_reg[eul2rot_pkg::LANE_PITCH] <= TRIG_ONE) &&
                 (cos_reg[eul2rot_pkg::LANE_PITCH] >= -TRIG_ONE))
    `ASSERT_IMPL(a_sin_pitch_bound, aclk, aresetn, trig_valid_reg,
                 (sin_reg[eul2rot_pkg::LANE_PITCH] <= TRIG_ONE) &&
                 (sin_reg[eul2rot_pkg::LANE_PITCH] >= -TRIG_ONE))

endmodule

// ----- verif/tb_euler_to_rotation_matrix_core.sv -----
// Testbench for euler_to_rotation_matrix_core: Euler angle words in, rotation matrix words out.
// Depends on eul2rot_pkg and the core RTL. A scoreboard class predicts every matrix
// through its own CORDIC and product rounding and checks the output words in order.
`timescale 1ns / 1ps

module tb_euler_to_rotation_matrix_core;
    import eul2rot_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int LATENCY      = CORDIC_STAGES_DEF + 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 180;
    localparam int BURST_WORDS  = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int ROT_STAGES   = 16;
    localparam int COEF_FRAC    = 14;
    localparam int XY_FRAC      = 30;
    localparam longint UNITY    = 64'sd1 <<< COEF_FRAC;
    localparam longint CORDIC_X0 = 64'sd652032874;

    localparam logic [31:0] ARCTAN_TURN [ROT_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    class matrix_scoreboard;
        logic [OUT_DATA_BITS-1:0] expected_matrices[$];
        int mismatches;

        function longint clamp_unity(input longint v);
            if (v > UNITY) return UNITY;
            if (v < -UNITY) return -UNITY;
            return v;
        endfunction

        function longint round_shift(input longint v, input int sh);
            return (v + (64'sd1 <<< (sh - 1))) >>> sh;
        endfunction

        function longint mul_round(input longint a, input longint b);
            return round_shift(a * b, COEF_FRAC);
        endfunction

        function void sin_cos_of(input logic [FIELD_BITS-1:0] angle,
                                 output longint cos_q, output longint sin_q);
            logic [31:0] turn;
            longint z, x, y, nx;
            bit flip;
            turn = {angle, 16'h0000};
            z = longint'($signed(turn));
            x = CORDIC_X0;
            y = 0;
            flip = 0;
            if (z > 64'sh40000000) begin
                z = z - 64'sh80000000;
                flip = 1;
            end else if (z < -64'sh40000000) begin
                z = z + 64'sh80000000;
                flip = 1;
            end
            for (int i = 0; i < ROT_STAGES; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - longint'(ARCTAN_TURN[i]);
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + longint'(ARCTAN_TURN[i]);
                end
                x = nx;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            cos_q = clamp_unity(round_shift(x, XY_FRAC - COEF_FRAC));
            sin_q = clamp_unity(round_shift(y, XY_FRAC - COEF_FRAC));
        endfunction

        function logic [OUT_DATA_BITS-1:0] predict_matrix(input logic [IN_DATA_BITS-1:0] angles);
            longint cy, sy, cp, sp, cr, sr, cysp, sysp;
            longint entry [NUM_ENTRIES];
            logic [OUT_DATA_BITS-1:0] word;
            sin_cos_of(angles[0*FIELD_BITS +: FIELD_BITS], cy, sy);
            sin_cos_of(angles[1*FIELD_BITS +: FIELD_BITS], cp, sp);
            sin_cos_of(angles[2*FIELD_BITS +: FIELD_BITS], cr, sr);
            cysp = mul_round(cy, sp);
            sysp = mul_round(sy, sp);
            entry[0] = mul_round(cp, cy);
            entry[1] = mul_round(cysp, sr) - mul_round(cr, sy);
            entry[2] = mul_round(cysp, cr) + mul_round(sy, sr);
            entry[3] = mul_round(cp, sy);
            entry[4] = mul_round(sysp, sr) + mul_round(cr, cy);
            entry[5] = mul_round(sysp, cr) - mul_round(cy, sr);
            entry[6] = -sp;
            entry[7] = mul_round(sr, cp);
            entry[8] = mul_round(cr, cp);
            for (int k = 0; k < NUM_ENTRIES; k++)
                word[k*FIELD_BITS +: FIELD_BITS] = FIELD_BITS'(clamp_unity(entry[k]));
            return word;
        endfunction

        function void note_angles(input logic [IN_DATA_BITS-1:0] angles);
            expected_matrices.insert(expected_matrices.size(), predict_matrix(angles));
        endfunction

        function void check_matrix(input logic [OUT_DATA_BITS-1:0] got);
            logic [OUT_DATA_BITS-1:0] want;
            if (expected_matrices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected matrix word %h", got);
                return;
            end
            want = expected_matrices.pop_front();
            for (int k = 0; k < NUM_ENTRIES; k++) begin
                if (got[k*FIELD_BITS +: FIELD_BITS] !== want[k*FIELD_BITS +: FIELD_BITS]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: entry m%0d%0d expected %0d got %0d", k / 3, k % 3,
                                 $signed(want[k*FIELD_BITS +: FIELD_BITS]),
                                 $signed(got[k*FIELD_BITS +: FIELD_BITS]));
                end
            end
        endfunction

        function int pending();
            return expected_matrices.size();
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;

    matrix_scoreboard sb;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int cycles;

    euler_to_rotation_matrix_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("euler_to_rotation_matrix_core verification failed");
            $finish;
        end
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_angles(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_matrix(m_tdata);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready = 1'b0;
            end else if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function logic [FIELD_BITS-1:0] pick_angle();
        logic [FIELD_BITS-1:0] a;
        case ($urandom_range(3))
            0, 1: a = FIELD_BITS'($urandom);
            2: a = FIELD_BITS'($urandom_range(7) * 8192 + $urandom_range(4) - 2);
            default: a = FIELD_BITS'($urandom_range(64) - 32);
        endcase
        return a;
    endfunction

    function logic [IN_DATA_BITS-1:0] pick_word();
        return {pick_angle(), pick_angle(), pick_angle()};
    endfunction

    // called and returns at a falling edge; valid stays high between back-to-back words
    task send_word(input logic [IN_DATA_BITS-1:0] word);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = word;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task send_angles(input int yaw, input int pitch, input int roll);
        send_word({FIELD_BITS'(roll), FIELD_BITS'(pitch), FIELD_BITS'(yaw)});
    endtask

    task wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    initial begin
        sb = new();
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        cycles = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_angles(0, 0, 0);
        send_angles(32767, 32767, 32767);
        send_angles(-32768, -32768, -32768);
        send_angles(-1, -1, -1);
        send_angles(1, 1, 1);
        send_angles(16384, 16384, 16384);
        send_angles(-16384, -16384, -16384);
        send_angles(16383, 16385, -16383);
        send_angles(-16385, 16384, -32768);
        send_angles(8192, -8192, 24576);
        send_angles(-24576, 8192, -8192);
        send_angles(-32768, 0, 16384);
        send_angles(0, -32768, -16384);
        send_angles(16384, 0, -32768);
        send_angles(32767, -32768, 0);
        send_angles(-32768, 32767, 1);
        send_angles(5461, 10923, -5461);
        send_angles(-10923, 21845, 30000);
        send_angles(12345, -12345, 23456);
        send_angles(-1, 16384, 32767);
        wait_drained();

        // fill the pipeline against a stalled output, then pause until empty
        hold_requests = hold_requests + 1;
        for (int i = 0; i < BURST_WORDS; i++)
            send_word(pick_word());
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
                default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
            endcase
            for (int i = 0; i < PHASE_WORDS; i++)
                send_word(pick_word());
        end
        wait_drained();
        repeat (4 * LATENCY) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("euler_to_rotation_matrix_core verification clean");
        end else begin
            $display("euler_to_rotation_matrix_core verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/eul2rot_pkg.sv
design/eul2rot_cordic_cell.sv
design/eul2rot_matrix.sv
design/euler_to_rotation_matrix_core.sv
verif/tb_euler_to_rotation_matrix_core.sv
